### rtl/core/b58_pkg.sv
// shared types, constants and the character-to-digit map for the base58 decoder
package b58_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CARRY_W = 6;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned PROD_W  = 32;

  localparam logic [7:0]  RADIX         = 8'd58;
  localparam logic [23:0] LOG_RATIO_Q24 = 24'd12285077;
  localparam logic [32:0] Q24_ROUND_UP  = 33'd16777215;

  localparam logic [STAT_W-1:0] ST_DATA     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADCHAR  = 2'd2;
  localparam logic [STAT_W-1:0] ST_CAPACITY = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_CHK_MUL,
    S_CHK_CMP,
    S_SCAN_RD,
    S_SCAN_EV
  } state_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] digit;
  } digit_t;

  function automatic digit_t digit_of(input logic [CHAR_W-1:0] code);
    digit_t d;
    d.ok    = 1'b1;
    d.digit = '0;
    case (code) inside
      [8'h31:8'h39]: d.digit = DIGIT_W'(code - 8'h31);
      [8'h41:8'h48]: d.digit = DIGIT_W'(code - 8'h41 + 8'd9);
      [8'h4A:8'h4E]: d.digit = DIGIT_W'(code - 8'h4A + 8'd17);
      [8'h50:8'h5A]: d.digit = DIGIT_W'(code - 8'h50 + 8'd22);
      [8'h61:8'h6B]: d.digit = DIGIT_W'(code - 8'h61 + 8'd33);
      [8'h6D:8'h7A]: d.digit = DIGIT_W'(code - 8'h6D + 8'd44);
      default:       d.ok    = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/b58_value_ram.sv
// byte store of the big number: one write port, one registered read port
module b58_value_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/b58_byte_mac.sv
// one limb of the multiply-by-58-and-add step
module b58_byte_mac (
  input  logic [b58_pkg::BYTE_W-1:0]  byte_in,
  input  logic [b58_pkg::CARRY_W-1:0] carry_in,
  output logic [b58_pkg::BYTE_W-1:0]  byte_out,
  output logic [b58_pkg::CARRY_W-1:0] carry_out
);
  import b58_pkg::*;

  logic [13:0] sum;

  // max 255*58 + 58 stays below 2^14, carry stays below 64
  assign sum       = 14'(byte_in) * 14'(RADIX) + 14'(carry_in);
  assign byte_out  = sum[7:0];
  assign carry_out = sum[13:8];

endmodule

### rtl/core/base58_string_decoder.sv
// top level of the base58 string decoder: control sequencer, check and output register
//
// usage
// - input channel (in_valid/in_ready): one character item per handshake, in_last_char
//   marks the final character of a string
// - result channel (out_valid/out_ready): decoded bytes most significant first, or one
//   status item (empty, invalid character, capacity too small); out_last_out marks the
//   final result item of the string
// - config channel (cfg_valid/cfg_ready): writes the output capacity in bytes, always
//   ready, write only while no string is in flight
// - character processing: each character runs a read-modify-write pass over the byte
//   memory, one byte per cycle with the carry rippling upward; an invalid character
//   skips the pass
// - after the final character: the capacity check (multiply, then compare), then a read and
//   an evaluate step per byte scanned from the capacity downward (leading zeros are skipped, not emitted)
// - the result sits in an output register, so a stalled receiver only holds the scan and the check;
//   the next string's characters are taken while the last result still waits
// - reset clears control state and sets the capacity to 64; the byte memory is not
//   cleared, it reads as zero until the first full pass of each string
module base58_string_decoder #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic       out_last_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_out_capacity
);
  import b58_pkg::*;

  localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [AW-1:0]    TOP_IDX = AW'(MAX_BYTES - 1);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAX_BYTES);

  state_t state_r, state_nxt;

  // control state
  logic [CAP_W-1:0]   cfg_cap_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               bad_r, bad_nxt;
  logic               clr_r, clr_nxt;      // memory reads as zero until a full pass
  logic               last_r, last_nxt;    // current character ends the string
  logic               lead_r, lead_nxt;    // still in leading zero bytes

  // datapath state
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;

  // output register
  logic               out_valid_r;
  logic [7:0]         out_data_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_last_r;

  digit_t             dig;
  logic               out_free;
  logic               load;
  logic [7:0]         load_data;
  logic [STAT_W-1:0]  load_status;
  logic               load_last;
  logic               end_str;

  logic               mem_we;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;
  logic [7:0]         byte_cur;
  logic [7:0]         mac_byte;
  logic [CARRY_W-1:0] mac_carry;
  logic [32:0]        need_sum;
  logic [8:0]         needed;
  logic               cap_fail;

  assign dig      = digit_of(in_char_code);
  assign out_free = !out_valid_r || out_ready;
  assign byte_cur = clr_r ? 8'd0 : mem_rdata;

  assign need_sum = {1'b0, prod_r} + Q24_ROUND_UP;
  assign needed   = need_sum[32:24];
  assign cap_fail = needed > {2'b00, cap_r};

  b58_value_ram #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (idx_r),
    .wr_data (mac_byte),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  b58_byte_mac u_mac (
    .byte_in   (byte_cur),
    .carry_in  (carry_r),
    .byte_out  (mac_byte),
    .carry_out (mac_carry)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (dig.ok) begin
            state_nxt = S_PASS;
          end else if (in_last_char) begin
            state_nxt = S_CHK_MUL;
          end
        end
      end
      S_PASS: begin
        if (idx_r == TOP_IDX) begin
          state_nxt = last_r ? S_CHK_MUL : S_IDLE;
        end
      end
      S_CHK_MUL: state_nxt = S_CHK_CMP;
      S_CHK_CMP: begin
        if (cap_fail || bad_r) begin
          if (out_free) begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (lead_r && byte_cur == 8'd0 && idx_r != '0) begin
          state_nxt = S_SCAN_RD;
        end else if (out_free) begin
          state_nxt = (idx_r == '0) ? S_IDLE : S_SCAN_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = idx_r;
    load        = 1'b0;
    load_data   = 8'd0;
    load_status = ST_DATA;
    load_last   = 1'b0;
    end_str     = 1'b0;
    cnt_nxt     = cnt_r;
    bad_nxt     = bad_r;
    clr_nxt     = clr_r;
    last_nxt    = last_r;
    lead_nxt    = lead_r;
    idx_nxt     = idx_r;
    carry_nxt   = carry_r;
    prod_nxt    = prod_r;
    cap_nxt     = cap_r;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = '0;
        if (in_valid) begin
          cnt_nxt   = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);
          bad_nxt   = bad_r || !dig.ok;
          last_nxt  = in_last_char;
          idx_nxt   = '0;
          carry_nxt = dig.digit;
        end
      end
      S_PASS: begin
        mem_we    = 1'b1;
        mem_raddr = idx_r + AW'(1);
        carry_nxt = mac_carry;
        idx_nxt   = idx_r + AW'(1);
        if (idx_r == TOP_IDX) begin
          clr_nxt = 1'b0;
        end
      end
      S_CHK_MUL: begin
        prod_nxt = PROD_W'(cnt_r) * PROD_W'(LOG_RATIO_Q24);
        cap_nxt  = (cfg_cap_r > CAP_MAX) ? CAP_MAX : cfg_cap_r;
      end
      S_CHK_CMP: begin
        lead_nxt = 1'b1;
        idx_nxt  = AW'(cap_r - CAP_W'(1));
        if (cap_fail || bad_r) begin
          load_status = cap_fail ? ST_CAPACITY : ST_BADCHAR;
          load_last   = 1'b1;
          if (out_free) begin
            load    = 1'b1;
            end_str = 1'b1;
          end
        end
      end
      S_SCAN_RD: begin
      end
      S_SCAN_EV: begin
        if (lead_r && byte_cur == 8'd0 && idx_r != '0) begin
          // skip a leading zero byte
          idx_nxt = idx_r - AW'(1);
        end else begin
          load_last = (idx_r == '0);
          if (lead_r && byte_cur == 8'd0) begin
            load_status = ST_EMPTY;
          end else begin
            load_data   = byte_cur;
            load_status = ST_DATA;
          end
          if (out_free) begin
            load     = 1'b1;
            lead_nxt = 1'b0;
            idx_nxt  = idx_r - AW'(1);
            end_str  = (idx_r == '0);
          end
        end
      end
      default: begin
      end
    endcase
    if (end_str) begin
      cnt_nxt = '0;
      bad_nxt = 1'b0;
      clr_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_cap_r   <= 7'd64;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
      clr_r       <= 1'b1;
      last_r      <= 1'b0;
      lead_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        cfg_cap_r <= cfg_out_capacity;
      end
      cnt_r  <= cnt_nxt;
      bad_r  <= bad_nxt;
      clr_r  <= clr_nxt;
      last_r <= last_nxt;
      lead_r <= lead_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    carry_r <= carry_nxt;
    prod_r  <= prod_nxt;
    cap_r   <= cap_nxt;
    if (load) begin
      out_data_r   <= load_data;
      out_status_r <= load_status;
      out_last_r   <= load_last;
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_r;
  assign out_status    = out_status_r;
  assign out_last_out  = out_last_r;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for base58_string_decoder: directed strings, capacity edges, random traffic
module testbench;
  import b58_pkg::*;

  localparam int MAX_BYTES     = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // worst case after the final character: check plus a read and evaluate scan step per byte
  localparam int SETTLE_CYCLES = 2 * MAX_BYTES + 40;
  localparam longint unsigned LOG58_Q24 = 64'd12285077;
  localparam longint unsigned Q24_CEIL  = 64'd16777215;
  // bitcoin alphabet, digit 0 in the top byte
  localparam logic [58*8-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [7:0]        data;
    logic [STAT_W-1:0] status;
    logic              last;
  } dec_item_t;

  // clock and dut ports, all inputs known from time zero
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic [1:0] out_status;
  logic       out_last_out;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_out_capacity = 7'd64;

  base58_string_decoder #(
    .MAX_BYTES(MAX_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_status      (out_status),
    .out_last_out    (out_last_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_out_capacity(cfg_out_capacity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle knobs, changed per phase
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // decoder state as the block should hold it
  logic [7:0]  acc_bytes [MAX_BYTES];
  int unsigned char_total = 0;
  bit          saw_bad_char = 1'b0;
  logic [6:0]  capacity_setting = 7'd64;
  dec_item_t   decoded_items [$];

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base58_string_decoder regression: fail");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [7:0] alphabet_char(input int idx);
    return ALPHABET[(57 - idx) * 8 +: 8];
  endfunction

  // digit of a character, -1 when outside the alphabet
  function automatic int char_digit(input logic [7:0] code);
    for (int i = 0; i < 58; i++) begin
      if (alphabet_char(i) == code) return i;
    end
    return -1;
  endfunction

  function automatic void expect_item(input logic [7:0] data, input logic [STAT_W-1:0] status,
                                      input logic last);
    dec_item_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    decoded_items.push_back(r);
  endfunction

  // multiply-accumulate one character; on the final one queue what the string decodes to
  task automatic accumulate_char(input logic [7:0] code, input logic last);
    int              d;
    int              top;
    int unsigned     carry;
    int unsigned     t;
    int unsigned     cap_bytes;
    longint unsigned needed;
    // first character of a string starts from zero
    if (char_total == 0) begin
      foreach (acc_bytes[i]) acc_bytes[i] = 8'h00;
      saw_bad_char = 1'b0;
    end
    if (char_total < 255) char_total++;
    d = char_digit(code);
    if (d < 0) begin
      saw_bad_char = 1'b1;
    end else begin
      // carry out of the top byte is dropped
      carry = d;
      for (int i = 0; i < MAX_BYTES; i++) begin
        t            = acc_bytes[i] * 58 + carry;
        acc_bytes[i] = t[7:0];
        carry        = t >> 8;
      end
    end
    if (last) begin
      cap_bytes = (capacity_setting > MAX_BYTES) ? MAX_BYTES : capacity_setting;
      needed    = (64'(char_total) * LOG58_Q24 + Q24_CEIL) >> 24;
      // capacity wins over a bad character
      if (needed > cap_bytes) begin
        expect_item(8'h00, ST_CAPACITY, 1'b1);
      end else if (saw_bad_char) begin
        expect_item(8'h00, ST_BADCHAR, 1'b1);
      end else begin
        // strip leading zero bytes, no zero byte restored for leading ones
        for (top = int'(cap_bytes) - 1; top >= 0; top--) begin
          if (acc_bytes[top] != 8'h00) break;
        end
        if (top < 0) begin
          expect_item(8'h00, ST_EMPTY, 1'b1);
        end else begin
          for (int i = top; i >= 0; i--) expect_item(acc_bytes[i], ST_DATA, i == 0);
        end
      end
      char_total   = 0;
      saw_bad_char = 1'b0;
    end
  endtask

  // result checker against the oldest queued expectation
  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk) begin : check_results
    dec_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_items.size() == 0) begin
        note_mismatch($sformatf("unexpected item data %02h status %0d last %0b",
                                out_data_byte, out_status, out_last_out));
      end else begin
        want = decoded_items.pop_front();
        if (out_data_byte !== want.data || out_status !== want.status ||
            out_last_out !== want.last) begin
          note_mismatch($sformatf(
            "expected data %02h status %0d last %0b, got data %02h status %0d last %0b",
            want.data, want.status, want.last, out_data_byte, out_status, out_last_out));
        end
      end
    end
  end

  // one character item, with an optional random gap in front
  task automatic send_char(input logic [7:0] code, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_char_code <= code;
    in_last_char <= last;
    do @(posedge clk); while (!in_ready);
    accumulate_char(code, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // stop sending, wait for every queued item, then let the block go quiet
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_out_capacity <= value;
    do @(posedge clk); while (!cfg_ready);
    capacity_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // short strings: zero value, single digits, leading ones, bad characters
  task automatic test_directed_values();
    write_capacity(7'd64);
    send_text("1");
    send_text("z");
    send_text("111");
    send_text("11z");
    send_text("2z");
    send_text("zzzz");
    send_text("1112");
    // invalid characters: nul alone, top code mid-string, the zero character
    send_char(8'h00, 1'b1);
    send_char("5", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("J", 1'b1);
    send_char("0", 1'b1);
    // clean string right after a bad one
    send_text("9");
  endtask

  // capacity extremes and the capacity-before-bad-character order
  task automatic test_capacity_limits();
    write_capacity(7'd1);
    send_text("z");
    send_text("zz");
    send_char("0", 1'b0);
    send_char("z", 1'b1);
    write_capacity(7'd0);
    send_text("1");
    write_capacity(7'd127);
    send_text("zz");
    write_capacity(7'd2);
    send_text("zz");
  endtask

  // count saturation on a string past 255 characters
  task automatic test_long_strings();
    int len;
    write_capacity(7'd64);
    len = $urandom_range(256, 258);
    for (int i = 0; i < len; i++) send_char(alphabet_char($urandom_range(57)), i == len - 1);
    // count must restart after the saturated string
    send_text("z");
  endtask

  // mostly well-formed strings with random content, some noise and bad characters
  task automatic run_phase(input int n_items, input int idle_pct, input int stall_v,
                           input logic [6:0] cap);
    logic [7:0] chars [$];
    logic [7:0] code;
    int         len;
    int         ones;
    int         sent;
    write_capacity(cap);
    send_idle_pct = idle_pct;
    stall_pct     = stall_v;
    sent          = 0;
    while (sent < n_items) begin
      chars.delete();
      len  = ($urandom_range(7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      ones = ($urandom_range(5) == 0) ? $urandom_range(1, len) : 0;
      for (int i = 0; i < len; i++) begin
        if (i < ones) chars.push_back("1");
        else if ($urandom_range(19) == 0) chars.push_back(8'($urandom_range(255)));
        else chars.push_back(alphabet_char($urandom_range(57)));
      end
      // a broken string now and then
      if ($urandom_range(9) == 0) begin
        do code = 8'($urandom_range(255)); while (char_digit(code) >= 0);
        chars[$urandom_range(len - 1)] = code;
      end
      for (int i = 0; i < len; i++) send_char(chars[i], i == len - 1);
      sent += len;
      // now and then the sender holds off until everything has come back
      if ($urandom_range(19) == 0) drain_results();
    end
  endtask

  task automatic test_random_traffic();
    run_phase(5, 0, 0, 7'd64);
    run_phase(5, 80, 0, 7'($urandom_range(2, 20)));
    run_phase(5, 0, 80, 7'd127);
    run_phase(5, 25, 25, 7'($urandom_range(1, 64)));
  endtask

  initial begin
    foreach (acc_bytes[i]) acc_bytes[i] = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_values();
    test_capacity_limits();
    test_long_strings();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("base58_string_decoder regression: pass");
    end else begin
      $display("base58_string_decoder regression: fail");
    end
    $finish;
  end

endmodule
